// ===== src/tbt_pkg.sv =====
// ----------------------------------------------------------------------------
// tbt_pkg
// shared types and codes for the timer bank: modes, timer states and the
// control word that steers the update stage
// ----------------------------------------------------------------------------
package tbt_pkg;

  localparam int unsigned ModeWidth   = 2;
  localparam int unsigned IndexWidth  = 8;
  localparam int unsigned EndWidth    = 16;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [ModeWidth-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OFF     = 2'd0,
    ST_STOPPED = 2'd1,
    ST_RUNNING = 2'd2,
    ST_REACHED = 2'd3
  } status_e;

  // what the update stage needs to know about the word in flight
  typedef struct packed {
    mode_e                 mode;
    logic                  target;
    logic [EndWidth-1:0]   end_value;
  } upd_ctrl_t;

endpackage

// ===== src/tbt_cell.sv =====
// ----------------------------------------------------------------------------
// tbt_cell
// one ring position: holds a timer's state and hands it on when the ring turns
// ----------------------------------------------------------------------------
module tbt_cell #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  tbt_pkg::status_e         status_i,
  input  logic [COUNT_WIDTH-1:0]   count_i,
  input  logic [COUNT_WIDTH-1:0]   limit_i,
  output tbt_pkg::status_e         status_o,
  output logic [COUNT_WIDTH-1:0]   count_o,
  output logic [COUNT_WIDTH-1:0]   limit_o
);
  import tbt_pkg::*;

  status_e                  status_q;
  logic [COUNT_WIDTH-1:0]   count_q;
  logic [COUNT_WIDTH-1:0]   limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_OFF;
    end else if (shift_i) begin
      status_q <= status_i;
    end
  end

  // count and limit are only read once a start has written them
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      count_q <= count_i;
      limit_q <= limit_i;
    end
  end

  assign status_o = status_q;
  assign count_o  = count_q;
  assign limit_o  = limit_q;

endmodule

// ===== src/tbt_update.sv =====
// ----------------------------------------------------------------------------
// tbt_update
// applies the current word to the timer passing the head of the ring
// ----------------------------------------------------------------------------
module tbt_update #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  tbt_pkg::upd_ctrl_t       ctrl_i,
  input  tbt_pkg::status_e         status_i,
  input  logic [COUNT_WIDTH-1:0]   count_i,
  input  logic [COUNT_WIDTH-1:0]   limit_i,
  output tbt_pkg::status_e         status_o,
  output logic [COUNT_WIDTH-1:0]   count_o,
  output logic [COUNT_WIDTH-1:0]   limit_o
);
  import tbt_pkg::*;

  logic [COUNT_WIDTH-1:0] count_inc;

  assign count_inc = count_i + COUNT_WIDTH'(1);

  always_comb begin
    status_o = status_i;
    count_o  = count_i;
    limit_o  = limit_i;
    case (ctrl_i.mode)
      MODE_TICK: begin
        if (status_i == ST_RUNNING) begin
          count_o = count_inc;
          if (count_inc >= limit_i) begin
            status_o = ST_REACHED;
          end
        end
      end
      MODE_START: begin
        if (ctrl_i.target) begin
          count_o  = '0;
          limit_o  = COUNT_WIDTH'(ctrl_i.end_value);
          status_o = ST_RUNNING;
        end
      end
      MODE_STOP: begin
        if (ctrl_i.target) begin
          status_o = ST_STOPPED;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/timer_bank_tick_top.sv =====
// ----------------------------------------------------------------------------
// timer_bank_tick_top
// bank of one-shot timers kept in a rotating ring of cells
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) takes one word: mode, timer index
//   and end value. output channel (out_valid_o / out_stall_i) returns one
//   word per input word: the indexed timer's status after the step.
//   the timers sit in a ring of NUM_TIMERS cells; a word is applied while
//   the ring turns once, one timer passing the update stage per cycle, save
//   that it holds at its final step while the output register is full.
//   the result is written into the output register at the edge ending the pass.
//   in_stall_o is high for the whole pass, so the next word is taken after
//   the pass at the earliest: no new word is taken while a pass runs.
//   a new word may be taken while the last result still waits; if the
//   receiver still stalls when the next pass ends, the ring holds at its
//   final step until the output register frees up.
//   reset sets every timer off at once; no clearing pass is needed.
//   out of range indexes report off, ticks still advance the whole bank.
// ----------------------------------------------------------------------------
module timer_bank_tick_top #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tbt_pkg::ModeWidth-1:0]       mode_i,
  input  logic [tbt_pkg::IndexWidth-1:0]      timer_index_i,
  input  logic [tbt_pkg::EndWidth-1:0]        end_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tbt_pkg::StatusWidth-1:0]     timer_status_o
);
  import tbt_pkg::*;

  localparam int unsigned StepWidth = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [StepWidth-1:0] LastStep = StepWidth'(NUM_TIMERS - 1);

  // control
  logic                   busy_q, busy_d;
  logic [StepWidth-1:0]   step_q, step_d;
  mode_e                  mode_q;
  logic [IndexWidth-1:0]  idx_q;
  logic                   idx_ok_q;
  logic [EndWidth-1:0]    end_q;
  status_e                res_q;
  logic                   out_valid_q, out_valid_d;
  status_e                status_out_q;

  logic                   in_accept;
  logic                   out_free;
  logic                   last_step;
  logic                   shift;
  logic                   head_hit;
  upd_ctrl_t              upd_ctrl;

  // ring
  status_e                ring_status [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] ring_count  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] ring_limit  [NUM_TIMERS];
  status_e                upd_status;
  logic [COUNT_WIDTH-1:0] upd_count;
  logic [COUNT_WIDTH-1:0] upd_limit;

  assign in_stall_o = busy_q;
  assign in_accept  = in_valid_i && !busy_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_step  = (step_q == LastStep);
  assign shift      = busy_q && (!last_step || out_free);
  assign head_hit   = idx_ok_q && (step_q == idx_q[StepWidth-1:0]);

  assign upd_ctrl.mode      = mode_q;
  assign upd_ctrl.target    = head_hit;
  assign upd_ctrl.end_value = end_q;

  tbt_update #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_update (
    .ctrl_i  (upd_ctrl),
    .status_i(ring_status[0]),
    .count_i (ring_count[0]),
    .limit_i (ring_limit[0]),
    .status_o(upd_status),
    .count_o (upd_count),
    .limit_o (upd_limit)
  );

  // cell i takes from cell i+1; the updated head entry goes to the tail
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_ring
    if (i == NUM_TIMERS - 1) begin : g_tail
      tbt_cell #(
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .status_i(upd_status),
        .count_i (upd_count),
        .limit_i (upd_limit),
        .status_o(ring_status[i]),
        .count_o (ring_count[i]),
        .limit_o (ring_limit[i])
      );
    end else begin : g_body
      tbt_cell #(
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .status_i(ring_status[i+1]),
        .count_i (ring_count[i+1]),
        .limit_i (ring_limit[i+1]),
        .status_o(ring_status[i]),
        .count_o (ring_count[i]),
        .limit_o (ring_limit[i])
      );
    end
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_accept) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (shift) begin
      if (last_step) begin
        busy_d      = 1'b0;
        step_d      = '0;
        out_valid_d = 1'b1;
      end else begin
        step_d = step_q + StepWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q   <= mode_e'(mode_i);
      idx_q    <= timer_index_i;
      idx_ok_q <= ({1'b0, timer_index_i} < (IndexWidth+1)'(NUM_TIMERS));
      end_q    <= end_value_i;
      res_q    <= ST_OFF;
    end else if (shift && head_hit) begin
      res_q <= upd_status;
    end
    // the indexed timer may be the last one through the update stage
    if (shift && last_step) begin
      status_out_q <= head_hit ? upd_status : res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign timer_status_o = status_out_q;

`ifndef NO_ASSERTIONS
  a_accept_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy_q && (step_q == '0))
    else $error("accepted word did not start a pass");

  a_result_from_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy_q) && $past(last_step))
    else $error("result appeared without a finished pass");

  a_idle_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (step_q == '0))
    else $error("step counter moved while idle");

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && last_step && out_valid_q && out_stall_i) |=> busy_q && last_step)
    else $error("pass ended while output register was full");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the timer bank word by word against a behavioral copy of the bank
// or, for pinned rows, against a directed table: the table first, then random
// ticks, starts, stops and queries with random idling on both channels, one
// long output hold-off, a mid-run drain and a final drain
module testbench;

  import tbt_pkg::*;

  localparam int unsigned NUM_TIMERS  = 16;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned TimerBits   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned RAND_WORDS  = 500;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned DRAIN_LIMIT = 20000;

  typedef struct packed {
    mode_e                 mode;
    logic [IndexWidth-1:0] idx;
    logic [EndWidth-1:0]   end_value;
    logic                  pinned;
    status_e               want;
  } step_row_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic [ModeWidth-1:0]   mode_i         = MODE_QUERY;
  logic [IndexWidth-1:0]  timer_index_i  = '0;
  logic [EndWidth-1:0]    end_value_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic [StatusWidth-1:0] timer_status_o;

  // behavioral copy of the bank
  status_e                bank_state [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] bank_count [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] bank_limit [NUM_TIMERS];

  status_e status_due [$];
  int      mismatches  = 0;
  int      words_seen  = 0;
  bit      quiet       = 1'b0;
  bit      held_long   = 1'b0;

  step_row_t directed_rows [24] = '{
    '{MODE_QUERY, 8'd0,   16'h0000, 1'b1, ST_OFF},
    '{MODE_QUERY, 8'd255, 16'hffff, 1'b1, ST_OFF},
    '{MODE_TICK,  8'd0,   16'h0000, 1'b1, ST_OFF},
    '{MODE_START, 8'd0,   16'h0000, 1'b1, ST_RUNNING},
    // zero limit is reached on the first tick
    '{MODE_TICK,  8'd0,   16'h0000, 1'b1, ST_REACHED},
    '{MODE_START, 8'd1,   16'h0002, 1'b1, ST_RUNNING},
    '{MODE_TICK,  8'd1,   16'h0000, 1'b0, ST_OFF},
    '{MODE_TICK,  8'd1,   16'h0000, 1'b0, ST_OFF},
    '{MODE_TICK,  8'd1,   16'h0000, 1'b0, ST_OFF},
    '{MODE_STOP,  8'd1,   16'h0000, 1'b1, ST_STOPPED},
    '{MODE_TICK,  8'd1,   16'h0000, 1'b0, ST_OFF},
    '{MODE_START, 8'd1,   16'h0003, 1'b1, ST_RUNNING},
    '{MODE_START, 8'd0,   16'h0001, 1'b1, ST_RUNNING},
    '{MODE_START, 8'd15,  16'hffff, 1'b1, ST_RUNNING},
    '{MODE_STOP,  8'd15,  16'h0000, 1'b1, ST_STOPPED},
    '{MODE_START, 8'd15,  16'h0005, 1'b1, ST_RUNNING},
    '{MODE_START, 8'd15,  16'h0004, 1'b1, ST_RUNNING},
    '{MODE_START, 8'd16,  16'h0007, 1'b1, ST_OFF},
    '{MODE_STOP,  8'd200, 16'h0000, 1'b1, ST_OFF},
    // out of range tick still moves the whole bank
    '{MODE_TICK,  8'd255, 16'h0000, 1'b1, ST_OFF},
    '{MODE_QUERY, 8'd0,   16'h0000, 1'b0, ST_OFF},
    '{MODE_QUERY, 8'd1,   16'h0000, 1'b0, ST_OFF},
    '{MODE_STOP,  8'd2,   16'h0000, 1'b1, ST_STOPPED},
    '{MODE_QUERY, 8'd15,  16'h0000, 1'b0, ST_OFF}
  };

  timer_bank_tick_top #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .timer_index_i  (timer_index_i),
    .end_value_i    (end_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .timer_status_o (timer_status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic status_e advance_bank(input mode_e m, input logic [IndexWidth-1:0] idx,
                                           input logic [EndWidth-1:0] ev);
    bit in_range;
    in_range = 32'(idx) < NUM_TIMERS;
    case (m)
      MODE_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (bank_state[i] == ST_RUNNING) begin
            bank_count[i] = bank_count[i] + COUNT_WIDTH'(1);
            if (bank_count[i] >= bank_limit[i]) bank_state[i] = ST_REACHED;
          end
        end
      end
      MODE_START: begin
        if (in_range) begin
          bank_count[idx[TimerBits-1:0]] = '0;
          bank_limit[idx[TimerBits-1:0]] = ev[COUNT_WIDTH-1:0];
          bank_state[idx[TimerBits-1:0]] = ST_RUNNING;
        end
      end
      MODE_STOP: begin
        if (in_range) bank_state[idx[TimerBits-1:0]] = ST_STOPPED;
      end
      default: ;
    endcase
    return in_range ? bank_state[idx[TimerBits-1:0]] : ST_OFF;
  endfunction

  // offer one word, wait for it to be taken, then note what it must return
  task automatic send_word(input mode_e m, input logic [IndexWidth-1:0] idx,
                           input logic [EndWidth-1:0] ev, input logic pinned,
                           input status_e want);
    status_e got;
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    timer_index_i <= idx;
    end_value_i   <= ev;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    got = advance_bank(m, idx, ev);
    status_due.push_back(pinned ? want : got);
  endtask

  // output side: stall at random, one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (words_seen >= 120 && !held_long) begin
        held_long = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due.size() == 0) begin
        flag_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
      end else if (timer_status_o !== status_due[0]) begin
        flag_mismatch($sformatf("word %0d timer_status got %0d want %0d",
                                words_seen, timer_status_o, status_due[0]));
        void'(status_due.pop_front());
      end else begin
        void'(status_due.pop_front());
      end
      words_seen++;
    end
  end

  initial begin
    mode_e                 m;
    logic [IndexWidth-1:0] idx;
    logic [EndWidth-1:0]   ev;
    int                    pick;
    int                    guard;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      bank_state[i] = ST_OFF;
      bank_count[i] = '0;
      bank_limit[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      send_word(directed_rows[r].mode, directed_rows[r].idx, directed_rows[r].end_value,
                directed_rows[r].pinned, directed_rows[r].want);

    for (int n = 0; n < RAND_WORDS; n++) begin
      quiet = (n >= 300 && n < 400);
      if (n == 250) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (status_due.size() != 0);
      end
      pick = $urandom_range(99);
      if (pick < 40) m = MODE_TICK;
      else if (pick < 65) m = MODE_START;
      else if (pick < 75) m = MODE_STOP;
      else m = MODE_QUERY;
      // mostly real timers, a few out of range
      if ($urandom_range(99) < 10) idx = IndexWidth'($urandom_range(255, NUM_TIMERS));
      else idx = IndexWidth'($urandom_range(NUM_TIMERS - 1));
      // short limits so timers actually get reached
      if ($urandom_range(99) < 80) ev = EndWidth'($urandom_range(10));
      else ev = EndWidth'($urandom);
      send_word(m, idx, ev, 1'b0, ST_OFF);
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    guard = 0;
    while (status_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * NUM_TIMERS) @(posedge clk_i);
    if (status_due.size() != 0)
      flag_mismatch($sformatf("%0d words never returned", status_due.size()));

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== timer_bank_tick_top.f =====
src/tbt_pkg.sv
src/tbt_cell.sv
src/tbt_update.sv
src/timer_bank_tick_top.sv
sim/testbench.sv
